/* hw/rtl/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
// Used by rational_arithmetic_unit, its port checker and the testbench; depends on nothing.
package rau_pkg;

  localparam int OP_W   = 16;           // operand field width
  localparam int MAG_W  = 2 * OP_W;     // magnitude of a product or sum
  localparam int NUM_W  = 33;           // signed numerator and compare fields
  localparam int DEN_W  = 31;           // unsigned denominator field
  localparam int OPC_W  = 3;
  localparam int MUL_W  = OP_W + 1;     // signed multiplier operand
  localparam int ALU_W  = MAG_W + 2;    // shared add/subtract unit
  localparam int CNT_W  = $clog2(MAG_W);

  typedef enum logic [OPC_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_MUL_T,
    ST_SUM,
    ST_MUL_D,
    ST_ABS_N,
    ST_ABS_D,
    ST_GCD,
    ST_DIV_N,
    ST_DIV_D,
    ST_SIGN,
    ST_CMP_MUL0,
    ST_CMP_MUL1,
    ST_CMP_SUM,
    ST_OUT
  } state_t;

  // Which reduction the sequencer is running.
  typedef enum logic [1:0] {
    PH_ARITH,
    PH_A,
    PH_B,
    PH_L
  } phase_t;

endpackage

/* hw/rtl/rational_arithmetic_unit.sv */
// Rational add, subtract, multiply, divide and compare with gcd reduction.
// Depends on rau_pkg for widths, operation codes and sequencer states.

// The unit works on one item at a time: in_ready is high only while the sequencer is idle.
// A finished result moves to the output register as soon as that register is free, and the
// next item is accepted while that result still waits there. An item with a zero denominator,
// a zero divisor or an unused operation code goes straight from the idle to the output state.
// An arithmetic item first forms the products and the absolute values, and a zero numerator
// then finishes through the sign and output states. Any other arithmetic item runs a binary
// gcd loop that does one shift, swap or subtract per cycle, then two 32-step restoring
// divisions by the gcd and the sign and output states. A compare item reduces both operands
// that way, then takes the gcd of the two reduced denominators to scale both to their lcm.
// The gcd loop and the 32-step divisions set the time. One 34-bit add/subtract unit carries
// every gcd step, division step and sum, and one 17x17 multiplier forms all products.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OPC_W-1:0]        op,
  input  logic signed [OP_W-1:0]  a_num,
  input  logic signed [OP_W-1:0]  a_den,
  input  logic signed [OP_W-1:0]  b_num,
  input  logic signed [OP_W-1:0]  b_den,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [NUM_W-1:0] res_num,
  output logic [DEN_W-1:0]        res_den,
  output logic signed [NUM_W-1:0] cmp_value,
  output logic                    div_zero_error
);

  state_t state, state_next;
  phase_t phase;
  op_t    op_r;

  logic signed [OP_W-1:0] an, ad, bn, bd;
  logic [NUM_W-1:0]       nr, dr, tr, cr;
  logic                   nneg, dneg, er;
  logic [MAG_W-1:0]       u, v, g, qr, rem;
  logic [CNT_W-1:0]       k, cnt;
  logic signed [MUL_W-1:0] xn_s, yn_s;
  logic [OP_W-1:0]        xd, yd, xs, ys;

  logic signed [MUL_W-1:0]   mul_x, mul_y;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [NUM_W-1:0]          mul_res;
  logic [ALU_W-1:0]          alu_x, alu_y, alu_s;
  logic                      alu_sub, alu_borrow;
  logic [MAG_W:0]            div_sh;
  logic [MAG_W-1:0]          rem_next, q_next, gcd_g;
  logic [NUM_W-1:0]          sres;
  logic                      in_acc, out_free, in_err, in_bad, last_step, nr_zero;

  function automatic logic [ALU_W-1:0] sxa(input logic [NUM_W-1:0] x);
    return {{(ALU_W-NUM_W){x[NUM_W-1]}}, x};
  endfunction

  function automatic logic signed [MUL_W-1:0] sxm(input logic [OP_W-1:0] x);
    return {x[OP_W-1], x};
  endfunction

  function automatic logic [NUM_W-1:0] sxn(input logic [OP_W-1:0] x);
    return {{(NUM_W-OP_W){x[OP_W-1]}}, x};
  endfunction

  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;
  assign in_bad   = (op > OP_CMP);
  assign in_err   = (a_den == '0) || (b_den == '0) || ((op == OP_DIV) && (b_num == '0));

  assign mul_p   = mul_x * mul_y;
  assign mul_res = mul_p[NUM_W-1:0];

  assign alu_s      = alu_x + (alu_y ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);
  assign alu_borrow = alu_s[ALU_W-1];

  // Restoring division step: the remainder stays below the divisor.
  assign div_sh    = {rem, qr[MAG_W-1]};
  assign rem_next  = alu_borrow ? div_sh[MAG_W-1:0] : alu_s[MAG_W-1:0];
  assign q_next    = {qr[MAG_W-2:0], ~alu_borrow};
  assign last_step = (cnt == CNT_W'(MAG_W - 1));

  assign gcd_g   = v << k;
  assign sres    = (nneg ^ dneg) ? alu_s[NUM_W-1:0] : nr;
  assign nr_zero = (nr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_x      = '0;
    mul_y      = '0;
    alu_x      = '0;
    alu_y      = '0;
    alu_sub    = 1'b1;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (in_bad || in_err) begin
            state_next = ST_OUT;
          end else if (op == OP_CMP) begin
            state_next = ST_ABS_N;
          end else begin
            state_next = ST_MUL_N;
          end
        end
      end
      ST_MUL_N: begin
        mul_x = sxm(an);
        mul_y = (op_r == OP_MUL) ? sxm(bn) : sxm(bd);
        state_next = ((op_r == OP_ADD) || (op_r == OP_SUB)) ? ST_MUL_T : ST_MUL_D;
      end
      ST_MUL_T: begin
        mul_x = sxm(bn);
        mul_y = sxm(ad);
        state_next = ST_SUM;
      end
      ST_SUM: begin
        alu_x   = sxa(nr);
        alu_y   = sxa(tr);
        alu_sub = (op_r == OP_SUB);
        state_next = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_x = sxm(ad);
        mul_y = (op_r == OP_DIV) ? sxm(bn) : sxm(bd);
        state_next = ST_ABS_N;
      end
      ST_ABS_N: begin
        alu_y = sxa(nr);
        state_next = ST_ABS_D;
      end
      ST_ABS_D: begin
        alu_y = sxa(dr);
        state_next = nr_zero ? ST_SIGN : ST_GCD;
      end
      ST_GCD: begin
        alu_x = {2'b00, u};
        alu_y = {2'b00, v};
        if (u == '0) begin
          state_next = ST_DIV_N;
        end
      end
      ST_DIV_N: begin
        alu_x = {1'b0, div_sh};
        alu_y = {2'b00, g};
        if (last_step) begin
          state_next = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        alu_x = {1'b0, div_sh};
        alu_y = {2'b00, g};
        if (last_step) begin
          state_next = (phase == PH_L) ? ST_CMP_MUL0 : ST_SIGN;
        end
      end
      ST_SIGN: begin
        alu_y = sxa(nr);
        case (phase)
          PH_A:    state_next = ST_ABS_N;
          PH_B:    state_next = ST_GCD;
          default: state_next = ST_OUT;
        endcase
      end
      ST_CMP_MUL0: begin
        mul_x = xn_s;
        mul_y = {1'b0, xs};
        state_next = ST_CMP_MUL1;
      end
      ST_CMP_MUL1: begin
        mul_x = yn_s;
        mul_y = {1'b0, ys};
        state_next = ST_CMP_SUM;
      end
      ST_CMP_SUM: begin
        alu_x = sxa(tr);
        alu_y = sxa(nr);
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          op_r  <= op_t'(op);
          an    <= a_num;
          ad    <= a_den;
          bn    <= b_num;
          bd    <= b_den;
          phase <= (op == OP_CMP) ? PH_A : PH_ARITH;
          nr    <= '0;
          dr    <= '0;
          cr    <= '0;
          er    <= ~in_bad & in_err;
          if (!in_bad && !in_err && op == OP_CMP) begin
            nr <= sxn(a_num);
            dr <= sxn(a_den);
          end
        end
      end
      ST_MUL_N: nr <= mul_res;
      ST_MUL_T: tr <= mul_res;
      ST_SUM:   nr <= alu_s[NUM_W-1:0];
      ST_MUL_D: dr <= mul_res;
      ST_ABS_N: begin
        nneg <= nr[NUM_W-1];
        if (nr[NUM_W-1]) begin
          nr <= alu_s[NUM_W-1:0];
        end
      end
      ST_ABS_D: begin
        dneg <= dr[NUM_W-1];
        if (nr_zero) begin
          dr <= NUM_W'(1);
        end else begin
          u  <= nr[MAG_W-1:0];
          v  <= dr[NUM_W-1] ? alu_s[MAG_W-1:0] : dr[MAG_W-1:0];
          dr <= dr[NUM_W-1] ? {1'b0, alu_s[MAG_W-1:0]} : dr;
          k  <= '0;
        end
      end
      ST_GCD: begin
        if (u == '0) begin
          g   <= gcd_g;
          rem <= '0;
          cnt <= '0;
          qr  <= (phase == PH_L) ? MAG_W'(yd) : nr[MAG_W-1:0];
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (alu_borrow) begin
          u <= v;
          v <= u;
        end else begin
          // Both odd: the difference is even, so halve it at once.
          u <= alu_s[MAG_W:1];
        end
      end
      ST_DIV_N: begin
        rem <= rem_next;
        qr  <= q_next;
        cnt <= cnt + 1'b1;
        if (last_step) begin
          rem <= '0;
          cnt <= '0;
          if (phase == PH_L) begin
            xs <= q_next[OP_W-1:0];
            qr <= MAG_W'(xd);
          end else begin
            nr <= {1'b0, q_next};
            qr <= dr[MAG_W-1:0];
          end
        end
      end
      ST_DIV_D: begin
        rem <= rem_next;
        qr  <= q_next;
        cnt <= cnt + 1'b1;
        if (last_step) begin
          cnt <= '0;
          if (phase == PH_L) begin
            ys <= q_next[OP_W-1:0];
          end else begin
            dr <= {1'b0, q_next};
          end
        end
      end
      ST_SIGN: begin
        case (phase)
          PH_A: begin
            xn_s  <= sres[MUL_W-1:0];
            xd    <= dr[OP_W-1:0];
            nr    <= sxn(bn);
            dr    <= sxn(bd);
            phase <= PH_B;
          end
          PH_B: begin
            // Both operands are reduced; next find the gcd of their denominators.
            yn_s  <= sres[MUL_W-1:0];
            yd    <= dr[OP_W-1:0];
            u     <= MAG_W'(xd);
            v     <= MAG_W'(dr[OP_W-1:0]);
            k     <= '0;
            phase <= PH_L;
          end
          default: nr <= sres;
        endcase
      end
      ST_CMP_MUL0: nr <= mul_res;
      ST_CMP_MUL1: tr <= mul_res;
      ST_CMP_SUM: begin
        cr <= alu_s[NUM_W-1:0];
        nr <= '0;
        dr <= '0;
      end
      ST_OUT: begin
        if (out_free) begin
          res_num        <= nr;
          res_den        <= dr[DEN_W-1:0];
          cmp_value      <= cr;
          div_zero_error <= er;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/rau_checker.sv */
// Port-level checks for rational_arithmetic_unit, attached by the bind below.
// Depends on rau_pkg for field widths.
module rau_checker import rau_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [OPC_W-1:0]        op,
  input logic signed [OP_W-1:0]  a_num,
  input logic signed [OP_W-1:0]  a_den,
  input logic signed [OP_W-1:0]  b_num,
  input logic signed [OP_W-1:0]  b_den,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [NUM_W-1:0] res_num,
  input logic [DEN_W-1:0]        res_den,
  input logic signed [NUM_W-1:0] cmp_value,
  input logic                    div_zero_error
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(res_den)
      && $stable(cmp_value) && $stable(div_zero_error))
    else $error("output item changed while stalled");

  // The unit works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("unit accepted an item while busy");

  // An error item carries all-zero fields.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero_error |-> res_num == '0 && res_den == '0 && cmp_value == '0)
    else $error("error item with nonzero fields");

  // A result with a nonzero numerator has a denominator and never a compare value.
  a_arith: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_num != '0 |-> res_den != '0 && cmp_value == '0)
    else $error("nonzero numerator without a denominator");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

/* dv/tb_rational_arithmetic_unit.sv */
// Testbench for rational_arithmetic_unit: directed corner cases, then random operands
// under three idling patterns, every result checked against an in-bench fraction predictor.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
module tb_rational_arithmetic_unit import rau_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OPC_W-1:0] OP_CODE_MAX = '1;
  localparam int               MAX_REPORTS = 10;
  localparam int               DRAIN_CYCLES = 600;

  typedef struct {
    logic [OPC_W-1:0]        code;
    logic signed [OP_W-1:0]  an;
    logic signed [OP_W-1:0]  ad;
    logic signed [OP_W-1:0]  bn;
    logic signed [OP_W-1:0]  bd;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    logic signed [NUM_W-1:0] cmp;
    logic                    err;
  } fraction_entry_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OPC_W-1:0]        op = '0;
  logic signed [OP_W-1:0]  a_num = '0;
  logic signed [OP_W-1:0]  a_den = '0;
  logic signed [OP_W-1:0]  b_num = '0;
  logic signed [OP_W-1:0]  b_den = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [NUM_W-1:0] res_num;
  logic [DEN_W-1:0]        res_den;
  logic signed [NUM_W-1:0] cmp_value;
  logic                    div_zero_error;

  fraction_entry_t expected_fractions[$];
  int error_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  rational_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_num(res_num), .res_den(res_den), .cmp_value(cmp_value),
    .div_zero_error(div_zero_error)
  );

  always #6 clk = ~clk;

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint gcd_of(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Moves the sign to the numerator and divides out the common factor.
  task automatic reduce_ratio(input longint n, input longint d,
                              output longint rn, output longint rd);
    longint g;
    if (n == 0) begin
      rn = 0;
      rd = 1;
    end else begin
      g = gcd_of(mag_of(n), mag_of(d));
      rn = ((n < 0) != (d < 0)) ? -(mag_of(n) / g) : mag_of(n) / g;
      rd = mag_of(d) / g;
    end
  endtask

  task automatic predict_fraction(inout fraction_entry_t e);
    longint an, ad, bn, bd, n, d, rn, rd, xn, xd, yn, yd, l;
    an = longint'(e.an);
    ad = longint'(e.ad);
    bn = longint'(e.bn);
    bd = longint'(e.bd);
    e.num = '0;
    e.den = '0;
    e.cmp = '0;
    e.err = 1'b0;
    if (e.code > OP_CMP) return;
    if (ad == 0 || bd == 0 || (e.code == OP_DIV && bn == 0)) begin
      e.err = 1'b1;
      return;
    end
    if (e.code == OP_CMP) begin
      reduce_ratio(an, ad, xn, xd);
      reduce_ratio(bn, bd, yn, yd);
      l = (xd / gcd_of(xd, yd)) * yd;
      n = yn * (l / yd) - xn * (l / xd);
      e.cmp = n[NUM_W-1:0];
      return;
    end
    case (e.code)
      OP_ADD: begin
        n = an * bd + bn * ad;
        d = ad * bd;
      end
      OP_SUB: begin
        n = an * bd - bn * ad;
        d = ad * bd;
      end
      OP_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      default: begin
        n = an * bd;
        d = ad * bn;
      end
    endcase
    reduce_ratio(n, d, rn, rd);
    e.num = rn[NUM_W-1:0];
    e.den = rd[DEN_W-1:0];
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_fraction_op(logic [OPC_W-1:0] code, logic signed [OP_W-1:0] an,
                                  logic signed [OP_W-1:0] ad, logic signed [OP_W-1:0] bn,
                                  logic signed [OP_W-1:0] bd);
    fraction_entry_t e;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e.code = code;
    e.an = an;
    e.ad = ad;
    e.bn = bn;
    e.bd = bd;
    predict_fraction(e);
    expected_fractions.push_back(e);
    @(negedge clk);
  endtask

  // Mix of full-range values, small values, powers of two, multiples of 12 sharing factors, and extremes.
  function automatic logic signed [OP_W-1:0] pick_operand();
    logic signed [OP_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = OP_W'($urandom);
      4, 5, 6:    v = OP_W'($urandom_range(40) - 20);
      7: begin
        case ($urandom_range(4))
          0: v = {1'b1, {(OP_W-1){1'b0}}};
          1: v = {1'b0, {(OP_W-1){1'b1}}};
          2: v = '1;
          3: v = OP_W'(1);
          default: v = '0;
        endcase
      end
      8: v = OP_W'(1) << $urandom_range(OP_W - 1);
      default: v = OP_W'(($urandom_range(2000) - 1000) * 12);
    endcase
    if ($urandom_range(1) == 1 && $urandom_range(9) == 8) v = -v;
    return v;
  endfunction

  function automatic logic [OPC_W-1:0] pick_code();
    if ($urandom_range(99) < 4) return OPC_W'($urandom_range(OP_CODE_MAX, OP_CMP + 1));
    return OPC_W'($urandom_range(OP_CMP, OP_ADD));
  endfunction

  task automatic run_random_items(int count);
    repeat (count)
      send_fraction_op(pick_code(), pick_operand(), pick_operand(), pick_operand(),
                       pick_operand());
  endtask

  task automatic test_directed_cases();
    logic signed [OP_W-1:0] mn, mx;
    mn = {1'b1, {(OP_W-1){1'b0}}};
    mx = {1'b0, {(OP_W-1){1'b1}}};
    src_idle_pct = 30;
    sink_idle_pct = 50;
    send_fraction_op(OP_ADD, 1, 2, 1, 3);
    send_fraction_op(OP_SUB, 1, 2, 1, 2);
    send_fraction_op(OP_MUL, mn, mx, mx, mn);
    send_fraction_op(OP_DIV, 3, 4, -3, 8);
    send_fraction_op(OP_CMP, 1, 3, 2, 6);
    send_fraction_op(OP_CMP, mn, 1, mx, 1);
    send_fraction_op(OP_ADD, mn, mn, mn, mn);
    send_fraction_op(OP_SUB, mn, 1, mx, 1);
    send_fraction_op(OP_MUL, mn, -1, mn, -1);
    send_fraction_op(OP_DIV, mn, 1, 1, mn);
    send_fraction_op(OP_ADD, mx, mn, mx, mn);
    send_fraction_op(OP_SUB, mx, mn, mn, mx);
    send_fraction_op(OP_MUL, 0, -5, 7, 3);
    send_fraction_op(OP_DIV, 0, 9, -4, 5);
    send_fraction_op(OP_CMP, 5, -7, -5, 7);
    send_fraction_op(OP_CMP, 0, 5, 0, -3);
    send_fraction_op(OP_CMP, mx, mx - 1, mx - 1, mx);
    // Zero denominators and a zero divisor must raise the error flag.
    send_fraction_op(OP_ADD, 3, 0, 1, 2);
    send_fraction_op(OP_CMP, 3, 4, 1, 0);
    send_fraction_op(OP_DIV, 3, 4, 0, 5);
    // Unused codes give an all-zero result, even with a zero denominator.
    send_fraction_op(OPC_W'(OP_CMP + 1), mn, mx, -1, 1);
    send_fraction_op(OPC_W'(OP_CMP + 2), 7, 3, 2, 5);
    send_fraction_op(OP_CODE_MAX, 1, 0, 1, 0);
  endtask

  task automatic test_slow_receiver();
    src_idle_pct = 30;
    sink_idle_pct = 84;
    run_random_items(360);
  endtask

  task automatic test_slow_sender();
    src_idle_pct = 84;
    sink_idle_pct = 30;
    run_random_items(360);
  endtask

  task automatic test_full_rate();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_random_items(360);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    fraction_entry_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_fractions.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: num %0d den %0d cmp %0d err %0b",
                   res_num, res_den, cmp_value, div_zero_error);
      end else begin
        e = expected_fractions.pop_front();
        if (res_num !== e.num || res_den !== e.den || cmp_value !== e.cmp ||
            div_zero_error !== e.err) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"mismatch op %0d a %0d/%0d b %0d/%0d: ",
                      "expected %0d/%0d cmp %0d err %0b, got %0d/%0d cmp %0d err %0b"},
                     e.code, e.an, e.ad, e.bn, e.bd, e.num, e.den, e.cmp, e.err,
                     res_num, res_den, cmp_value, div_zero_error);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_cases();
    test_slow_receiver();
    test_slow_sender();
    test_full_rate();
    in_valid <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_rational_arithmetic_unit passed");
    end else begin
      $display("tb_rational_arithmetic_unit failed");
    end
    $finish;
  end

  // Allows several times the worst-case run time before declaring failure.
  initial begin
    #50_000_000;
    $display("tb_rational_arithmetic_unit failed");
    $finish;
  end

endmodule

/* rational_arithmetic_unit.f */
hw/rtl/rau_pkg.sv
hw/rtl/rational_arithmetic_unit.sv
hw/rtl/rau_checker.sv
dv/tb_rational_arithmetic_unit.sv
